// ----- sv/ps2mc_pkg.sv -----
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Fixed field widths of the two streams
  localparam int unsigned DATA_BYTE_W = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned DELTA_X_W   = 8;
  localparam int unsigned DELTA_Y_W   = 9;
  localparam int unsigned BUTTONS_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam int unsigned OUT_FIELDS_W = 2 * POS_W + DELTA_X_W + DELTA_Y_W + BUTTONS_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Header byte bit positions
  localparam int unsigned HDR_SYNC_BIT  = 3;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;
  localparam int unsigned HDR_XOVF_BIT  = 6;
  localparam int unsigned HDR_YOVF_BIT  = 7;

  localparam logic signed [DELTA_X_W-1:0] DELTA_SAT = 8'sd127;

  localparam int unsigned RESET_MAX_X    = 1023;
  localparam int unsigned RESET_MAX_Y    = 767;
  localparam int unsigned RESET_CURSOR_X = 512;
  localparam int unsigned RESET_CURSOR_Y = 384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_MAX_X  = 2'd1,
    REG_MAX_Y  = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  // Position within a three-byte packet
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

endpackage

// ----- sv/ps2_mouse_packet_cursor_unit.sv -----
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a clamped cursor.
// Input stream: one controller byte per beat on in_tdata, in_tuser set when
// the byte came from the mouse channel. Bytes are dropped while enable is
// clear or in_tuser is low. Three-byte packets are gathered; a header byte
// with bit 3 clear is dropped so the stream resynchronizes.
// Output stream: one beat per completed packet carrying the clamped cursor,
// the X delta, the negated Y delta and the three button bits.
// Configuration: write enable, max_x and max_y over cfg_* while idle;
// cfg_ready is always high.
// Result: a completed packet's beat is registered in the output or skid entry.
// Throughput: one byte per cycle while in_tready is high; the update is one adder
// and a clamp to 0..max per axis between the packet state and the result register.
// Stall: a two-entry result buffer (output register plus skid) lets one more
// packet complete while out_tready is low; in_tready drops only when both
// entries are full.
// Reset: enable clears, max_x/max_y go to 1023/767, the cursor to 512,384,
// and packet gathering restarts at the header byte.
module ps2_mouse_packet_cursor_unit
  import ps2mc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // in_tdata: [7:0] data_byte
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  // in_tuser: [0] from_aux
  input  logic                    in_tuser,
  // out_tdata: [11:0] pos_x, [23:12] pos_y, [31:24] delta_x, [40:32] delta_y,
  //            [43:41] buttons, [47:44] zero
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned SUM_W = COORD_WIDTH + 2;

  // Configuration registers
  logic                   enable_r;
  logic [COORD_WIDTH-1:0] max_x_r;
  logic [COORD_WIDTH-1:0] max_y_r;

  // Packet and cursor state
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             header_r, header_nxt;
  logic [7:0]             x_byte_r, x_byte_nxt;
  logic [COORD_WIDTH-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_WIDTH-1:0] cursor_y_r, cursor_y_nxt;

  // Result buffer
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;

  logic                   in_fire;
  logic                   byte_live;
  logic                   res_fire;
  logic                   out_take;

  logic signed [DELTA_X_W-1:0] dx;
  logic signed [DELTA_X_W-1:0] dy;
  logic signed [DELTA_Y_W-1:0] dy_neg;
  logic signed [SUM_W-1:0]     sum_x;
  logic signed [SUM_W-1:0]     sum_y;
  logic [COORD_WIDTH-1:0]      new_x;
  logic [COORD_WIDTH-1:0]      new_y;
  logic [OUT_TDATA_W-1:0]      res_data;

  assign in_tready  = !skid_valid_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_fire   = in_tvalid && in_tready;
  assign byte_live = in_fire && enable_r && in_tuser;
  assign res_fire  = byte_live && (phase_r == PH_Y);
  assign out_take  = out_valid_r && out_tready;

  // Configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      max_x_r  <= COORD_WIDTH'(RESET_MAX_X);
      max_y_r  <= COORD_WIDTH'(RESET_MAX_Y);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_MAX_X:  max_x_r  <= COORD_WIDTH'(cfg_data);
        REG_MAX_Y:  max_y_r  <= COORD_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // Deltas: sign-extend, overflow saturates with the header sign
  always_comb begin
    if (header_r[HDR_XOVF_BIT]) begin
      dx = header_r[HDR_XSIGN_BIT] ? -DELTA_SAT : DELTA_SAT;
    end else begin
      dx = $signed(x_byte_r);
    end
    if (header_r[HDR_YOVF_BIT]) begin
      dy = header_r[HDR_YSIGN_BIT] ? -DELTA_SAT : DELTA_SAT;
    end else begin
      dy = $signed(in_tdata);
    end
    dy_neg = -(DELTA_Y_W'(dy));

    // Move the cursor: X grows right, packet Y grows up so subtract it
    sum_x = $signed({2'b00, cursor_x_r}) + SUM_W'(dx);
    sum_y = $signed({2'b00, cursor_y_r}) - SUM_W'(dy);

    // Clamp to 0..max
    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x > $signed({2'b00, max_x_r})) begin
      new_x = max_x_r;
    end else begin
      new_x = sum_x[COORD_WIDTH-1:0];
    end
    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y > $signed({2'b00, max_y_r})) begin
      new_y = max_y_r;
    end else begin
      new_y = sum_y[COORD_WIDTH-1:0];
    end

    res_data = OUT_TDATA_W'({header_r[BUTTONS_W-1:0], dy_neg, dx,
                             POS_W'(new_y), POS_W'(new_x)});
  end

  // Packet phase machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      header_r   <= '0;
      x_byte_r   <= '0;
      cursor_x_r <= COORD_WIDTH'(RESET_CURSOR_X);
      cursor_y_r <= COORD_WIDTH'(RESET_CURSOR_Y);
    end else begin
      phase_r    <= phase_nxt;
      header_r   <= header_nxt;
      x_byte_r   <= x_byte_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    header_nxt   = header_r;
    x_byte_nxt   = x_byte_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (byte_live) begin
      unique case (phase_r)
        PH_HEADER: begin
          // drop a header without the sync bit
          if (in_tdata[HDR_SYNC_BIT]) begin
            header_nxt = in_tdata;
            phase_nxt  = PH_X;
          end
        end
        PH_X: begin
          x_byte_nxt = in_tdata;
          phase_nxt  = PH_Y;
        end
        PH_Y: begin
          cursor_x_nxt = new_x;
          cursor_y_nxt = new_y;
          phase_nxt    = PH_HEADER;
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Result buffer: output register backed by one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (res_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  // skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // dropped bytes leave the packet phase alone
  a_drop_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (!enable_r || !in_tuser)) |=> $stable(phase_r))
    else $error("dropped byte moved the packet phase");

  // a third byte always closes the packet and yields a result beat
  a_third_byte_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_live && phase_r == PH_Y) |=> (phase_r == PH_HEADER && out_valid_r))
    else $error("third byte did not complete the packet");
`endif

endmodule
